FILE: rtl/core/seed_hit_score_accumulator_macros.svh
// assertion macros used by the checker of the seed hit score accumulator
`ifndef SEED_HIT_SCORE_ACCUMULATOR_MACROS_SVH
`define SEED_HIT_SCORE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, off while reset is low
`define SHSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("seed hit score accumulator: check failed");

// next-cycle implication, off while reset is low
`define SHSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("seed hit score accumulator: check failed");

`endif

FILE: rtl/core/shsa_pkg.sv
package shsa_pkg;

    // width of the id, position and count fields on the ports
    localparam int FIELD_W = 16;

    // status flags reported with each result item
    typedef struct packed {
        logic first_touch;
        logic counted;
        logic pruned;
    } t_hit_flags;

endpackage

FILE: rtl/core/shsa_idx_mod.sv
module shsa_idx_mod #(
    parameter int DEPTH = 65536,
    parameter int IDX_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [shsa_pkg::FIELD_W-1:0] i_seq_id,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_idx
);

    // reciprocal of the table depth, scaled by 2^32
    localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / DEPTH);
    localparam logic [16:0] DIVISOR = 17'(DEPTH);

    logic        r_v1, r_v2, r_v3;
    logic [15:0] r_x1, r_x2;
    logic [15:0] r_q1;
    logic [16:0] r_qd2;
    logic [IDX_W-1:0] r_idx3;

    logic [48:0] w_prod1;
    logic [33:0] w_prod2;
    logic [16:0] w_rem;
    logic [16:0] w_fix;

    // quotient estimate, then its product, then one correction step
    assign w_prod1 = {33'd0, i_seq_id} * {16'd0, RECIP};
    assign w_prod2 = {17'd0, 1'b0, r_q1} * {17'd0, DIVISOR};
    assign w_rem   = {1'b0, r_x2} - r_qd2;
    assign w_fix   = (w_rem >= DIVISOR) ? (w_rem - DIVISOR) : w_rem;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // data pipe
    always_ff @(posedge i_clk) begin
        r_x1   <= i_seq_id;
        r_q1   <= w_prod1[47:32];
        r_x2   <= r_x1;
        r_qd2  <= w_prod2[16:0];
        r_idx3 <= w_fix[IDX_W-1:0];
    end

    assign o_valid = r_v3;
    assign o_idx   = r_idx3;

endmodule

FILE: rtl/core/shsa_table.sv
module shsa_table #(
    parameter int DEPTH  = 65536,
    parameter int IDX_W  = 16,
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/seed_hit_score_accumulator.sv
// Per-sequence seed hit counter. Each input item names a sequence, a query
// position and the number of query positions still to come; each one gives
// exactly one result item with the sequence's score after the hit and the
// first-touch, counted and pruned flags. A hit does not count again while its
// query position equals the last one recorded for its table word, and scores
// saturate. The score, the last recorded position and its valid bit share one
// word of a single table with a registered read port. The sequence id of an
// accepted item is reduced modulo the table depth in a 3-stage multiply
// pipeline, the table is then read, and the word is updated together with the
// loading of the output register. The next item is taken only after that
// result is loaded; a stalled result holds the item in flight and stall with
// it. After reset a clearing pass writes each of the min(SEQ_COUNT, 65536)
// table words, one a cycle; stall stays high until it is done. Write the
// cutoff threshold register only while no item is in flight: an item in
// flight uses the value held when its result is loaded.
module seed_hit_score_accumulator #(
    parameter int SEQ_COUNT  = 65536,
    parameter int SCORE_BITS = 16,
    parameter int POS_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_seq_id,
    input  logic [15:0] i_query_pos,
    input  logic [15:0] i_remaining,
    input  logic        i_last_in_batch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_hit_seq_id,
    output logic        o_first_touch,
    output logic        o_counted,
    output logic        o_pruned,
    output logic [15:0] o_score_after,
    output logic        o_batch_end
);

    localparam int FW     = shsa_pkg::FIELD_W;
    localparam int DEPTH  = (SEQ_COUNT < (2 ** FW)) ? SEQ_COUNT : (2 ** FW);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int WORD_W = SCORE_BITS + 1 + POS_BITS;
    localparam int SUM_W  = ((SCORE_BITS > FW) ? SCORE_BITS : FW) + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_IDX,
        S_CALC
    } t_state;

    t_state r_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic [15:0]         r_cutoff;
    logic [15:0]         r_sid;
    logic [POS_BITS-1:0] r_qpos;
    logic [15:0]         r_rem;
    logic                r_last;
    logic [IDX_W-1:0]    r_idx;

    logic                r_out_valid;
    logic [15:0]         r_out_sid;
    shsa_pkg::t_hit_flags r_flags;
    logic [15:0]         r_out_score;
    logic                r_out_last;

    logic                w_accept;
    logic                w_mod_valid;
    logic [IDX_W-1:0]    w_mod_idx;
    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_waddr;
    logic [WORD_W-1:0]   w_mem_wdata;
    logic                w_mem_re;
    logic [WORD_W-1:0]   w_rdata;

    logic [SCORE_BITS-1:0] w_score;
    logic                  w_pos_vld;
    logic [POS_BITS-1:0]   w_pos;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_prune;
    logic                  w_new_pos;
    logic                  w_inc;
    logic [SCORE_BITS-1:0] w_score_nx;
    logic                  w_load;
    shsa_pkg::t_hit_flags  n_flags;

    // input handshake: one item in flight at a time
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    // sequence id reduction to a table index
    shsa_idx_mod #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_idx_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_seq_id (i_seq_id),
        .o_valid  (w_mod_valid),
        .o_idx    (w_mod_idx)
    );

    // score, position valid and last position in one word
    shsa_table #(
        .DEPTH  (DEPTH),
        .IDX_W  (IDX_W),
        .DATA_W (WORD_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mod_idx),
        .o_rdata (w_rdata)
    );

    // unpack the word read for the current item
    assign w_score   = w_rdata[WORD_W-1 -: SCORE_BITS];
    assign w_pos_vld = w_rdata[POS_BITS];
    assign w_pos     = w_rdata[POS_BITS-1:0];

    // pruning, repeat detection and saturating increment
    always_comb begin
        w_sum      = SUM_W'(w_score) + SUM_W'(r_rem);
        w_prune    = (r_cutoff > 16'd1) && (w_sum < SUM_W'(r_cutoff));
        w_new_pos  = !w_pos_vld || (w_pos != r_qpos);
        w_inc      = !w_prune && w_new_pos && !(&w_score);
        w_score_nx = w_inc ? (w_score + SCORE_BITS'(1)) : w_score;
        n_flags.first_touch = !w_prune && (w_score == '0);
        n_flags.counted     = w_inc;
        n_flags.pruned      = w_prune;
    end

    // update fires once the output register can take the result
    assign w_load = (r_state == S_CALC) && (!r_out_valid || !i_stall);

    // table access: read enable, and clearing pass or write-back
    always_comb begin
        w_mem_re = (r_state == S_IDX) && w_mod_valid;
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_idx;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_load && !w_prune && w_new_pos;
            w_mem_waddr = r_idx;
            w_mem_wdata = {w_score_nx, 1'b1, r_qpos};
        end
    end

    // control, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_cutoff    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    if (w_mod_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // payload of the item in flight and of the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sid  <= i_seq_id;
            r_qpos <= POS_BITS'(i_query_pos);
            r_rem  <= i_remaining;
            r_last <= i_last_in_batch;
        end
        if (w_mem_re) begin
            r_idx <= w_mod_idx;
        end
        if (w_load) begin
            r_out_sid   <= r_sid;
            r_flags     <= n_flags;
            r_out_score <= 16'(w_score_nx);
            r_out_last  <= r_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit_seq_id  = r_out_sid;
    assign o_first_touch = r_flags.first_touch;
    assign o_counted     = r_flags.counted;
    assign o_pruned      = r_flags.pruned;
    assign o_score_after = r_out_score;
    assign o_batch_end   = r_out_last;

endmodule

FILE: rtl/core/shsa_checker.sv
`include "seed_hit_score_accumulator_macros.svh"

module shsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_hit_seq_id,
    input logic        o_first_touch,
    input logic        o_counted,
    input logic        o_pruned,
    input logic [15:0] o_score_after
);

    // a pruned hit touches nothing
    `SHSA_ASSERT_IMP(a_pruned_quiet, i_clk, i_rst_n, o_valid && o_pruned, !o_counted && !o_first_touch)

    // a first touch always counts and leaves a score of one
    `SHSA_ASSERT_IMP(a_first_counts, i_clk, i_rst_n, o_valid && o_first_touch, o_counted && (o_score_after == 16'd1))

    // one item in flight: intake closes right after an accepted item
    `SHSA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a stalled result holds
    `SHSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_hit_seq_id) && $stable(o_score_after))

endmodule

bind seed_hit_score_accumulator shsa_checker u_shsa_checker (.*);
